FILE: design/binary_morphology_3x3_macros.svh
`ifndef BINARY_MORPHOLOGY_3X3_MACROS_SVH
`define BINARY_MORPHOLOGY_3X3_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define BMOR_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// once ante holds, cons must hold at the following edge
`define BMOR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bmor_pkg.sv
`timescale 1ns / 1ps

package bmor_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int PIX_W = 8;
  localparam int GEOM_W = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_INDEX_W = 2;

  localparam logic [GEOM_W-1:0] MIN_GEOM = 11'd3;
  localparam logic [GEOM_W-1:0] WIDTH_RESET = 11'd640;
  localparam logic [GEOM_W-1:0] HEIGHT_RESET = 11'd480;

  localparam logic [PIX_W-1:0] BACKGROUND = 8'd255;
  localparam logic [PIX_W-1:0] BORDER_MARK = 8'd0;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OP_MODE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FG_VALUE = 2'd3;

  typedef enum logic [1:0] {
    MODE_ERODE  = 2'd0,
    MODE_DILATE = 2'd1,
    MODE_BORDER = 2'd2,
    MODE_PASS   = 2'd3
  } mode_t;

  // window laid out row-major, top-left first
  typedef logic [8:0][PIX_W-1:0] win_t;
  typedef logic [8:0] win_ok_t;
  // one window column, top row first
  typedef logic [2:0][PIX_W-1:0] column_t;

  // line store entry: two rows back and one row back at the same column
  typedef struct packed {
    logic [PIX_W-1:0] up2;
    logic [PIX_W-1:0] up;
  } ls_word_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ls_ctrl_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             frame_end;
  } result_t;

  function automatic win_t make_win(column_t l, column_t m, column_t r);
    win_t v;
    for (int row = 0; row < 3; row++) begin
      v[row*3+0] = l[row];
      v[row*3+1] = m[row];
      v[row*3+2] = r[row];
    end
    return v;
  endfunction

  function automatic win_ok_t make_ok(logic top_ok, logic left_ok, logic right_ok,
                                      logic bottom_ok);
    win_ok_t ok;
    for (int row = 0; row < 3; row++) begin
      for (int col = 0; col < 3; col++) begin
        ok[row*3+col] = (row != 0 || top_ok) && (row != 2 || bottom_ok) &&
                        (col != 0 || left_ok) && (col != 2 || right_ok);
      end
    end
    return ok;
  endfunction

  function automatic logic [PIX_W-1:0] bmor_eval(win_t v, win_ok_t ok, mode_t mode,
                                                 logic [PIX_W-1:0] fg);
    logic all_fg;
    logic any_fg;
    logic centre_fg;
    logic [PIX_W-1:0] res;
    all_fg = 1'b1;
    any_fg = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (ok[i] && v[i] == fg) any_fg = 1'b1;
      else all_fg = 1'b0;
    end
    centre_fg = (v[4] == fg);
    case (mode)
      MODE_ERODE: res = centre_fg ? (all_fg ? fg : BACKGROUND) : v[4];
      MODE_DILATE: res = any_fg ? fg : v[4];
      MODE_BORDER: res = (centre_fg && !all_fg && fg != BACKGROUND) ? BORDER_MARK : BACKGROUND;
      default: res = v[4];
    endcase
    return res;
  endfunction

endpackage

FILE: design/binary_morphology_3x3.sv
// A request is registered in the evaluation stage, and its results in the buffer behind m_tvalid.
// Throughput: one request per cycle while the output buffer has room, set by the single
// read-modify-write pass on the line store; a row's last pixel yields two results, which holds
// the input until the two-entry buffer has room. Output is one row behind input; drains flush it.
// Reset: synchronous rst clears counters, pipeline, output buffer and sets registers to defaults;
// the line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`include "binary_morphology_3x3_macros.svh"

module binary_morphology_3x3 #(
  parameter int MAX_WIDTH = bmor_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // [7:0] pixel_in
  input  logic [0:0]                          s_tuser,   // [0] func
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata,   // [7:0] pixel_out
  output logic                                m_tlast,
  output logic [0:0]                          m_tuser,   // [0] frame_end
  input  logic                                cfg_we,
  input  logic [bmor_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bmor_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > bmor_pkg::GEOM_W) ? WW : bmor_pkg::GEOM_W;
  localparam logic [CW-1:0] W_MIN = CW'(bmor_pkg::MIN_GEOM);
  localparam logic [CW-1:0] W_MAX = CW'(MAX_WIDTH);
  localparam bmor_pkg::column_t ZERO_COL = '0;

  typedef struct packed {
    logic drain;
    logic top_ok;
    logic left_ok;
    logic right_ok;
    logic emit_mid;
    logic emit_end;
    logic left_from_b;
    logic last;
  } p1_flags_t;

  // configuration
  logic [bmor_pkg::GEOM_W-1:0] image_width;
  logic [bmor_pkg::GEOM_W-1:0] image_height;
  bmor_pkg::mode_t             op_mode;
  logic [7:0]                  fg_value;

  // position counters
  logic [AW-1:0]               col_count;
  logic [AW-1:0]               drain_count;
  logic [bmor_pkg::GEOM_W-1:0] row_count;

  // request stage
  logic [CW-1:0]               w_ext;
  logic [CW-1:0]               w_eff;
  logic [CW-1:0]               w_m1;
  logic [bmor_pkg::GEOM_W-1:0] h_eff;
  logic [AW-1:0]               c;
  logic [AW-1:0]               d;
  logic                        rowlast;
  logic                        frame_full;
  logic                        d_clamp;
  logic                        d_last;
  logic                        d_next_ok;
  logic                        s_accept;
  logic                        take_pix;
  logic                        take_drain;
  p1_flags_t                   p1_f_next;

  // line store access
  bmor_pkg::ls_ctrl_t          ls_ctrl;
  logic [AW-1:0]               rd_addr_a;
  logic [AW-1:0]               rd_addr_b;
  bmor_pkg::ls_word_t          rd_a;
  bmor_pkg::ls_word_t          rd_b;
  bmor_pkg::ls_word_t          ls_wr_data;

  // evaluation stage
  logic                        p1_valid;
  p1_flags_t                   p1_f;
  logic [7:0]                  p1_px;
  logic [AW-1:0]               p1_addr;
  bmor_pkg::column_t           pwin_l;
  bmor_pkg::column_t           pwin_r;
  bmor_pkg::ls_word_t          drain_prev;
  bmor_pkg::column_t           new_col;
  bmor_pkg::column_t           d_left;
  bmor_pkg::column_t           d_cent;
  bmor_pkg::column_t           d_right;
  logic [7:0]                  pix_mid;
  logic [7:0]                  pix_end;
  logic [7:0]                  drn_px;
  bmor_pkg::result_t           res0;
  bmor_pkg::result_t           res1;
  logic [1:0]                  nres;
  logic                        fire;

  // output buffer
  bmor_pkg::result_t           slot_a;
  bmor_pkg::result_t           slot_b;
  logic [1:0]                  slot_n;
  bmor_pkg::result_t           slot_a_next;
  bmor_pkg::result_t           slot_b_next;
  logic [1:0]                  slot_n_next;
  logic [1:0]                  base_n;
  logic [1:0]                  push_n;
  logic                        pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= bmor_pkg::WIDTH_RESET;
      image_height <= bmor_pkg::HEIGHT_RESET;
      op_mode <= bmor_pkg::MODE_ERODE;
      fg_value <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bmor_pkg::CFG_IMAGE_WIDTH: image_width <= cfg_data;
        bmor_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        bmor_pkg::CFG_OP_MODE: op_mode <= bmor_pkg::mode_t'(cfg_data[1:0]);
        bmor_pkg::CFG_FG_VALUE: fg_value <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_ext = CW'(image_width);
    if (w_ext < W_MIN) w_eff = W_MIN;
    else if (w_ext > W_MAX) w_eff = W_MAX;
    else w_eff = w_ext;
    w_m1 = w_eff - CW'(1);
    h_eff = (image_height < bmor_pkg::MIN_GEOM) ? bmor_pkg::MIN_GEOM : image_height;

    c = (CW'(col_count) < w_eff) ? col_count : w_m1[AW-1:0];
    rowlast = (CW'(c) >= w_m1);
    frame_full = (row_count >= h_eff);

    d_clamp = (CW'(drain_count) > w_m1);
    d = d_clamp ? w_m1[AW-1:0] : drain_count;
    d_last = (CW'(d) >= w_m1);
    d_next_ok = ((CW'(d) + CW'(1)) < w_eff);

    s_accept = s_tvalid && s_tready;
    take_pix = s_accept && !s_tuser[0] && !frame_full;
    take_drain = s_accept && s_tuser[0] && frame_full;

    p1_f_next.drain = s_tuser[0];
    p1_f_next.top_ok = (row_count >= bmor_pkg::GEOM_W'(2));
    p1_f_next.left_ok = s_tuser[0] ? (d != '0) : (c >= AW'(2));
    p1_f_next.right_ok = d_next_ok;
    p1_f_next.emit_mid = (row_count != '0) && (c != '0);
    p1_f_next.emit_end = (row_count != '0) && rowlast;
    p1_f_next.left_from_b = d_clamp;
    p1_f_next.last = d_last;

    // port b fetches the right column on a drain, or the left one when clamped at the edge
    rd_addr_a = s_tuser[0] ? d : c;
    if (s_tuser[0] && d_clamp) rd_addr_b = d - AW'(1);
    else if (s_tuser[0] && d_next_ok) rd_addr_b = d + AW'(1);
    else rd_addr_b = rd_addr_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      drain_count <= '0;
    end else if (take_pix) begin
      if (rowlast) begin
        col_count <= '0;
        row_count <= row_count + bmor_pkg::GEOM_W'(1);
        drain_count <= '0;
      end else begin
        col_count <= c + AW'(1);
      end
    end else if (take_drain) begin
      if (d_last) begin
        col_count <= '0;
        row_count <= '0;
        drain_count <= '0;
      end else begin
        drain_count <= d + AW'(1);
      end
    end
  end

  always_comb begin
    ls_ctrl.rd_en = take_pix || take_drain;
    ls_ctrl.wr_en = fire && !p1_f.drain;
    ls_wr_data.up2 = rd_a.up;
    ls_wr_data.up = p1_px;
  end

  bmor_line_mem #(
    .DEPTH(MAX_WIDTH)
  ) u_line_mem (
    .clk       (clk),
    .ctrl      (ls_ctrl),
    .wr_addr   (p1_addr),
    .wr_data   (ls_wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (s_tready) begin
      p1_valid <= take_pix || take_drain;
    end
  end

  always_ff @(posedge clk) begin
    if (take_pix || take_drain) begin
      p1_f <= p1_f_next;
      p1_px <= s_tdata;
      p1_addr <= c;
    end
  end

  always_comb begin
    new_col[0] = rd_a.up2;
    new_col[1] = rd_a.up;
    new_col[2] = p1_px;

    d_left[0] = p1_f.left_from_b ? rd_b.up2 : drain_prev.up2;
    d_left[1] = p1_f.left_from_b ? rd_b.up : drain_prev.up;
    d_left[2] = '0;
    d_cent[0] = rd_a.up2;
    d_cent[1] = rd_a.up;
    d_cent[2] = '0;
    d_right[0] = rd_b.up2;
    d_right[1] = rd_b.up;
    d_right[2] = '0;

    pix_mid = bmor_pkg::bmor_eval(bmor_pkg::make_win(pwin_l, pwin_r, new_col),
                                  bmor_pkg::make_ok(p1_f.top_ok, p1_f.left_ok, 1'b1, 1'b1),
                                  op_mode, fg_value);
    // row end: window shifted one more column, right side past the edge
    pix_end = bmor_pkg::bmor_eval(bmor_pkg::make_win(pwin_r, new_col, ZERO_COL),
                                  bmor_pkg::make_ok(p1_f.top_ok, 1'b1, 1'b0, 1'b1),
                                  op_mode, fg_value);
    drn_px = bmor_pkg::bmor_eval(bmor_pkg::make_win(d_left, d_cent, d_right),
                                 bmor_pkg::make_ok(1'b1, p1_f.left_ok, p1_f.right_ok, 1'b0),
                                 op_mode, fg_value);

    if (p1_f.drain) begin
      nres = 2'd1;
      res0 = '{pixel: drn_px, row_end: p1_f.last, frame_end: p1_f.last};
      res1 = res0;
    end else begin
      nres = {1'b0, p1_f.emit_mid} + {1'b0, p1_f.emit_end};
      if (p1_f.emit_mid) begin
        res0 = '{pixel: pix_mid, row_end: 1'b0, frame_end: 1'b0};
        res1 = '{pixel: pix_end, row_end: 1'b1, frame_end: 1'b0};
      end else begin
        res0 = '{pixel: pix_end, row_end: 1'b1, frame_end: 1'b0};
        res1 = res0;
      end
    end

    fire = p1_valid && (nres <= (2'd2 - slot_n));
    s_tready = !p1_valid || fire;
  end

  always_ff @(posedge clk) begin
    if (fire && !p1_f.drain) begin
      pwin_l <= pwin_r;
      pwin_r <= new_col;
    end
    if (fire && p1_f.drain) begin
      drain_prev <= rd_a;
    end
  end

  always_comb begin
    pop = (slot_n != '0) && m_tready;
    base_n = slot_n - {1'b0, pop};
    push_n = fire ? nres : 2'd0;
    slot_a_next = pop ? slot_b : slot_a;
    slot_b_next = slot_b;
    case (base_n)
      2'd0: begin
        if (push_n != '0) slot_a_next = res0;
        if (push_n == 2'd2) slot_b_next = res1;
      end
      2'd1: begin
        if (push_n != '0) slot_b_next = res0;
      end
      default: ;
    endcase
    slot_n_next = base_n + push_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_n <= '0;
    end else begin
      slot_n <= slot_n_next;
    end
  end

  always_ff @(posedge clk) begin
    slot_a <= slot_a_next;
    slot_b <= slot_b_next;
  end

  assign m_tvalid = (slot_n != '0);
  assign m_tdata = slot_a.pixel;
  assign m_tlast = slot_a.row_end;
  assign m_tuser[0] = slot_a.frame_end;

  `BMOR_ASSERT(a_no_rw_clash, !(ls_ctrl.wr_en && ls_ctrl.rd_en && (p1_addr == rd_addr_a || p1_addr == rd_addr_b)), "line store read hits the entry being written back")
  `BMOR_ASSERT(a_slots_bounded, slot_n != 2'd3, "output buffer overfilled")
  `BMOR_ASSERT_NEXT(a_drain_rearms, take_drain && d_last, row_count == '0 && col_count == '0 && drain_count == '0, "frame not rearmed after last drain")
  `BMOR_ASSERT_NEXT(a_ignored_pixel, s_accept && !s_tuser[0] && frame_full, !p1_valid, "pixel taken while awaiting drain")

endmodule

FILE: design/bmor_line_mem.sv
`timescale 1ns / 1ps

module bmor_line_mem #(
  parameter int DEPTH = bmor_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  bmor_pkg::ls_ctrl_t ctrl,
  input  logic [AW-1:0]      wr_addr,
  input  bmor_pkg::ls_word_t wr_data,
  input  logic [AW-1:0]      rd_addr_a,
  input  logic [AW-1:0]      rd_addr_b,
  output bmor_pkg::ls_word_t rd_data_a,
  output bmor_pkg::ls_word_t rd_data_b
);

  bmor_pkg::ls_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued, so a stalled stage keeps it
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule
